// ----- rtl/pbs_pkg.sv -----
// Shared types, constants and register codes for the power button sequencer.
`default_nettype none

package pbs_pkg;

  // Operating mode, encoded as reported on the result channel.
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_BOOT = 2'd1,
    MODE_RUN  = 2'd2,
    MODE_SHUT = 2'd3
  } mode_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOOT_TIMEOUT  = 2'd0,
    CFG_SHUT_TIMEOUT  = 2'd1,
    CFG_BOOT_BLINK    = 2'd2,
    CFG_SHUT_BLINK    = 2'd3
  } cfg_index_t;

  localparam int CFG_DATA_W = 10;
  localparam int SEC_W      = 8;
  localparam int MS_W       = 10;

  localparam logic [SEC_W-1:0] BOOT_TIMEOUT_RST = 8'd40;
  localparam logic [SEC_W-1:0] SHUT_TIMEOUT_RST = 8'd40;
  localparam logic [MS_W-1:0]  BOOT_BLINK_RST   = 10'd200;
  localparam logic [MS_W-1:0]  SHUT_BLINK_RST   = 10'd500;
  localparam logic [SEC_W-1:0] SEC_MAX          = 8'd255;

  localparam int MS_PER_SECOND_DEF = 1000;

  typedef struct packed {
    logic [SEC_W-1:0] boot_timeout_s;
    logic [SEC_W-1:0] shutdown_timeout_s;
    logic [MS_W-1:0]  boot_blink_ms;
    logic [MS_W-1:0]  shutdown_blink_ms;
  } pbs_cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic             prev_button;
    logic             prev_host_ready;
    logic             led;
    logic             power_cut;
    logic             request;
    logic [MS_W-1:0]  period_ms;
    logic [MS_W-1:0]  ms_accum;
    logic [SEC_W-1:0] elapsed_s;
  } pbs_state_t;

  typedef struct packed {
    logic  led;
    logic  power_cut;
    logic  shutdown_request;
    mode_t mode;
  } pbs_result_t;

endpackage

`default_nettype wire

// ----- rtl/pbs_ifs.sv -----
// Channel interfaces: millisecond tick input, result output and register writes.
`default_nettype none

interface pbs_in_if;
  logic valid;
  logic ready;
  logic button_level;
  logic host_ready_level;
  modport source (output valid, button_level, host_ready_level, input ready);
  modport sink   (input valid, button_level, host_ready_level, output ready);
endinterface

interface pbs_out_if;
  logic       valid;
  logic       ready;
  logic       led;
  logic       power_cut;
  logic       shutdown_request;
  logic [1:0] mode;
  modport source (output valid, led, power_cut, shutdown_request, mode, input ready);
  modport sink   (input valid, led, power_cut, shutdown_request, mode, output ready);
endinterface

interface pbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/power_button_sequencer.sv -----
// Top level of the power button sequencer: registers, result buffering and checks.
//
// Each tick item stands for one millisecond and carries the sampled button
// and host-ready levels; every tick yields exactly one result item holding
// the LED drive, the host power cut pin, the shutdown request and the mode
// (0 off, 1 booting, 2 running, 3 shutting down). The block takes one tick
// per clock cycle: the whole mode update is a single pass of logic on the
// sequencer state, and the result is registered into the output register.
// A skid register behind the output register takes the result instead and lets
// the block keep taking ticks while one result waits; tick ready drops
// only when both hold a result. Register writes are always ready and must
// be made while no tick is in flight.
`default_nettype none

module power_button_sequencer
  import pbs_pkg::*;
#(
  parameter int MS_PER_SECOND = MS_PER_SECOND_DEF
) (
  input  logic  clk,
  input  logic  rst,
  pbs_in_if.sink    tick,
  pbs_out_if.source result,
  pbs_cfg_if.sink   cfg
);

  pbs_cfg_t    cfg_regs;
  pbs_result_t res;
  pbs_result_t out_data;
  pbs_result_t skid_data;
  logic        out_valid;
  logic        skid_valid;
  logic        tick_fire;
  logic        out_free;

  // Configuration registers: take every write at once.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.boot_timeout_s     <= BOOT_TIMEOUT_RST;
      cfg_regs.shutdown_timeout_s <= SHUT_TIMEOUT_RST;
      cfg_regs.boot_blink_ms      <= BOOT_BLINK_RST;
      cfg_regs.shutdown_blink_ms  <= SHUT_BLINK_RST;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        CFG_BOOT_TIMEOUT: cfg_regs.boot_timeout_s     <= cfg.data[SEC_W-1:0];
        CFG_SHUT_TIMEOUT: cfg_regs.shutdown_timeout_s <= cfg.data[SEC_W-1:0];
        CFG_BOOT_BLINK:   cfg_regs.boot_blink_ms      <= cfg.data[MS_W-1:0];
        CFG_SHUT_BLINK:   cfg_regs.shutdown_blink_ms  <= cfg.data[MS_W-1:0];
        default: begin
          cfg_regs <= cfg_regs;
        end
      endcase
    end
  end

  // Hold off ticks only when both result slots are full.
  assign tick.ready = !skid_valid;
  assign tick_fire  = tick.valid && tick.ready;

  pbs_core #(
    .MS_PER_SECOND (MS_PER_SECOND)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg_regs),
    .advance          (tick_fire),
    .button_level     (tick.button_level),
    .host_ready_level (tick.host_ready_level),
    .res              (res)
  );

  // Output register is free when empty or being taken this cycle.
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          // Advance the parked item; no tick is taken this cycle.
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= tick_fire;
        end
      end else if (tick_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (tick_fire) begin
        out_data <= res;
      end
    end else if (tick_fire) begin
      skid_data <= res;
    end
  end

  assign result.valid            = out_valid;
  assign result.led              = out_data.led;
  assign result.power_cut        = out_data.power_cut;
  assign result.shutdown_request = out_data.shutdown_request;
  assign result.mode             = out_data.mode;

  // Host power is cut exactly when the mode is off.
  a_power_cut_mode: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.power_cut == (result.mode == MODE_OFF)))
    else $error("power cut disagrees with mode");

  // Shutdown is requested exactly while shutting down.
  a_request_mode: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.shutdown_request == (result.mode == MODE_SHUT)))
    else $error("shutdown request disagrees with mode");

  // LED is dark when off and lit when running.
  a_led_mode: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.mode != MODE_OFF || !result.led) &&
                      (result.mode != MODE_RUN || result.led)))
    else $error("LED state wrong for mode");

  // A parked item implies the output register is occupied.
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an item ahead of the output register");

endmodule

`default_nettype wire

// ----- rtl/pbs_core.sv -----
// Mode sequencer state and its one-tick update.
`default_nettype none

module pbs_core
  import pbs_pkg::*;
#(
  parameter int MS_PER_SECOND = MS_PER_SECOND_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  pbs_cfg_t    cfg,
  input  logic        advance,
  input  logic        button_level,
  input  logic        host_ready_level,
  output pbs_result_t res
);

  localparam logic [MS_W:0] MS_SUM = (MS_W+1)'(MS_PER_SECOND);

  pbs_state_t st;
  pbs_state_t st_next;

  logic             btn_rise;
  logic             rdy_rise;
  logic             booting;
  logic [MS_W-1:0]  blink;
  logic [SEC_W-1:0] timeout;
  logic [MS_W:0]    period_inc;
  logic             period_end;
  logic [MS_W:0]    sum;
  logic             sec_wrap;
  logic [MS_W:0]    sum_adj;
  logic [MS_W-1:0]  acc_sat;
  logic [SEC_W-1:0] elapsed_edge;
  logic [SEC_W-1:0] elapsed_inc;
  logic             timeout_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode            <= MODE_OFF;
      st.prev_button     <= 1'b0;
      st.prev_host_ready <= 1'b0;
      st.led             <= 1'b0;
      st.power_cut       <= 1'b1;
      st.request         <= 1'b0;
      st.period_ms       <= '0;
      st.ms_accum        <= '0;
      st.elapsed_s       <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Datapath pieces shared by boot and shutdown.
  always_comb begin
    btn_rise     = button_level && !st.prev_button;
    rdy_rise     = host_ready_level && !st.prev_host_ready;
    booting      = (st.mode == MODE_BOOT);
    blink        = booting ? cfg.boot_blink_ms : cfg.shutdown_blink_ms;
    timeout      = booting ? cfg.boot_timeout_s : cfg.shutdown_timeout_s;
    elapsed_edge = (rdy_rise && booting) ? cfg.boot_timeout_s : st.elapsed_s;
    period_inc   = {1'b0, st.period_ms} + (MS_W+1)'(1);
    period_end   = (period_inc >= {1'b0, blink});
    sum          = {1'b0, st.ms_accum} + {1'b0, blink};
    sec_wrap     = (sum >= MS_SUM);
    sum_adj      = sec_wrap ? (sum - MS_SUM) : sum;
    acc_sat      = sum_adj[MS_W] ? '1 : sum_adj[MS_W-1:0];
    elapsed_inc  = (sec_wrap && (elapsed_edge != SEC_MAX)) ?
                   (elapsed_edge + SEC_W'(1)) : elapsed_edge;
    timeout_hit  = (elapsed_inc >= timeout);
  end

  always_comb begin
    st_next                 = st;
    st_next.prev_button     = button_level;
    st_next.prev_host_ready = host_ready_level;
    st_next.elapsed_s       = elapsed_edge;
    case (st.mode)
      MODE_OFF: begin
        if (btn_rise) begin
          st_next.mode      = MODE_BOOT;
          st_next.power_cut = 1'b0;
          st_next.request   = 1'b0;
          st_next.led       = 1'b1;
          st_next.period_ms = '0;
          st_next.ms_accum  = '0;
          st_next.elapsed_s = '0;
        end
      end
      MODE_RUN: begin
        if (btn_rise) begin
          st_next.mode      = MODE_SHUT;
          st_next.request   = 1'b1;
          st_next.led       = 1'b1;
          st_next.period_ms = '0;
          st_next.ms_accum  = '0;
          st_next.elapsed_s = '0;
        end
      end
      MODE_BOOT, MODE_SHUT: begin
        if (period_end) begin
          st_next.ms_accum  = acc_sat;
          st_next.elapsed_s = elapsed_inc;
          if (timeout_hit) begin
            if (booting) begin
              st_next.mode = MODE_RUN;
              st_next.led  = 1'b1;
            end else begin
              st_next.mode      = MODE_OFF;
              st_next.power_cut = 1'b1;
              st_next.led       = 1'b0;
              st_next.request   = 1'b0;
            end
          end else begin
            st_next.led       = !st.led;
            st_next.period_ms = '0;
          end
        end else begin
          st_next.period_ms = period_inc[MS_W-1:0];
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  assign res.led              = st_next.led;
  assign res.power_cut        = st_next.power_cut;
  assign res.shutdown_request = st_next.request;
  assign res.mode             = st_next.mode;

endmodule

`default_nettype wire
